FILE: rtl/tuaq_pkg.sv
package tuaq_pkg;

	// Table size and derived widths.
	localparam int ALARM_SLOTS = 16;
	localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

	// Field widths.
	localparam int CMD_W = 3;
	localparam int SECS_W = 22;
	localparam int TAG_W = 16;
	localparam int CNT48_W = 48;
	localparam int MS_W = 10;
	localparam int UP_W = 58;
	localparam int QUANT_W = 16;
	localparam int PROD_W = SECS_W + MS_W;

	localparam logic [MS_W-1:0] MS_LAST = MS_W'(999);
	localparam logic [MS_W-1:0] MS_PER_SEC = MS_W'(1000);
	localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(10);

	// Stream payload widths.
	localparam int IN_BITS = SECS_W + TAG_W + CNT48_W;
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = TAG_W + 1 + 1 + UP_W + CNT48_W + CNT48_W + CNT_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	// Register file.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic {
		REG_ENABLE = 1'b0,
		REG_QUANTUM = 1'b1
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 3'd0,
		CMD_ADD = 3'd1,
		CMD_CANCEL = 3'd2,
		CMD_SET_WALL = 3'd3,
		CMD_STATUS = 3'd4
	} cmd_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic cancel;
		logic set_wall;
		logic tick;
		logic scan_step;
		logic pop;
		logic mul;
		logic add;
		logic find_step;
		logic sel_pos;
		logic insert;
		logic show_fire;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic due;
		logic find_more;
		logic reject;
		logic last_fire;
		logic any_fired;
	} dp_stat_t;

endpackage

FILE: rtl/tick_uptime_alarm_queue.sv
// Millisecond tick timer with a sorted queue of up to 16 alarms. Commands come
// in one at a time on the input stream: each gives zero or more alarm-fired
// results (tuser high) and then one status result (tuser low, tlast high), all
// carrying the counters as they stand after the command. An enabled tick steps
// the counters, scans for due alarms from the table head, then gives one fired
// result per due alarm; an add forms the trigger (multiply, then add), searches
// for its slot past the queued alarms with an earlier trigger and inserts it,
// or goes straight to status when refused; a disabled tick and the other
// commands go straight to status. The due scan and the sorted insert search
// read one table slot per cycle through a single read port. The next command is
// taken once the status transfer completes. The registers are written over the
// APB port: enable at byte address 0, ticks_per_quantum at byte address 4.
module tick_uptime_alarm_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tuaq_pkg::ADDR_W-1:0] paddr,
	input  logic [tuaq_pkg::DATA_W-1:0] pwdata,
	output logic [tuaq_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// Command stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// s_tdata: alarm_seconds[21:0], alarm_tag[37:22], new_wall_time[85:38], zeros
	input  logic [tuaq_pkg::IN_W-1:0]   s_tdata,
	// s_tuser: cmd[2:0]
	input  logic [tuaq_pkg::CMD_W-1:0]  s_tuser,
	// Result stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// m_tdata: fired_tag[15:0], status[16], quantum_expired[17], uptime_ms[75:18],
	// tick_total[123:76], wall_seconds[171:124], alarms_pending[176:172], zeros
	output logic [tuaq_pkg::OUT_W-1:0]  m_tdata,
	// m_tuser: kind
	output logic                        m_tuser,
	output logic                        m_tlast
);
	import tuaq_pkg::*;

	logic enable_q;
	logic [QUANT_W-1:0] quantum_q;
	reg_idx_t reg_idx;
	logic cfg_write;

	dp_cmd_t dp_cmd;
	dp_stat_t dp_stat;

	logic [TAG_W-1:0] fired_tag;
	logic status;
	logic quantum_expired;
	logic [UP_W-1:0] uptime_ms;
	logic [CNT48_W-1:0] tick_total;
	logic [CNT48_W-1:0] wall_seconds;
	logic [CNT_W-1:0] alarms_pending;

	// Register decode and write.
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			quantum_q <= QUANT_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_QUANTUM: quantum_q <= pwdata[QUANT_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read.
	always_comb begin
		unique case (reg_idx)
			REG_ENABLE: prdata = DATA_W'(enable_q);
			REG_QUANTUM: prdata = DATA_W'(quantum_q);
			default: prdata = '0;
		endcase
	end

	tuaq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_kind  (m_tuser),
		.out_last  (m_tlast),
		.out_ready (m_tready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	tuaq_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.dp_cmd            (dp_cmd),
		.dp_stat           (dp_stat),
		.ticks_per_quantum (quantum_q),
		.alarm_seconds     (s_tdata[SECS_W-1:0]),
		.alarm_tag         (s_tdata[SECS_W+TAG_W-1:SECS_W]),
		.new_wall_time     (s_tdata[IN_BITS-1:SECS_W+TAG_W]),
		.fired_tag         (fired_tag),
		.status            (status),
		.quantum_expired   (quantum_expired),
		.uptime_ms         (uptime_ms),
		.tick_total        (tick_total),
		.wall_seconds      (wall_seconds),
		.alarms_pending    (alarms_pending)
	);

	// Result payload, first field in the lowest bits.
	assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, alarms_pending, wall_seconds, tick_total,
		uptime_ms, quantum_expired, status, fired_tag};

endmodule

FILE: rtl/tuaq_ctrl.sv
module tuaq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enable,
	input  logic                       in_valid,
	input  logic [tuaq_pkg::CMD_W-1:0] in_cmd,
	output logic                       in_ready,
	output logic                       out_valid,
	output logic                       out_kind,
	output logic                       out_last,
	input  logic                       out_ready,
	output tuaq_pkg::dp_cmd_t          dp_cmd,
	input  tuaq_pkg::dp_stat_t         dp_stat
);
	import tuaq_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_TICK   = 9'b000000010,
		ST_SCAN   = 9'b000000100,
		ST_FIRE   = 9'b000001000,
		ST_MUL    = 9'b000010000,
		ST_ADD    = 9'b000100000,
		ST_FIND   = 9'b001000000,
		ST_INSERT = 9'b010000000,
		ST_STATUS = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	cmd_t cmd;

	assign cmd = cmd_t'(in_cmd);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		dp_cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_kind = 1'b0;
		out_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					case (cmd)
						CMD_TICK: state_d = enable ? ST_TICK : ST_STATUS;
						CMD_ADD: state_d = ST_MUL;
						CMD_CANCEL: begin
							dp_cmd.cancel = 1'b1;
							state_d = ST_STATUS;
						end
						CMD_SET_WALL: begin
							dp_cmd.set_wall = 1'b1;
							state_d = ST_STATUS;
						end
						default: state_d = ST_STATUS;
					endcase
				end
			end
			ST_TICK: begin
				dp_cmd.tick = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (dp_stat.due) begin
					dp_cmd.scan_step = 1'b1;
				end else begin
					state_d = dp_stat.any_fired ? ST_FIRE : ST_STATUS;
				end
			end
			ST_FIRE: begin
				out_valid = 1'b1;
				out_kind = 1'b1;
				dp_cmd.show_fire = 1'b1;
				if (out_ready) begin
					dp_cmd.pop = 1'b1;
					if (dp_stat.last_fire) begin
						state_d = ST_STATUS;
					end
				end
			end
			ST_MUL: begin
				dp_cmd.mul = 1'b1;
				state_d = dp_stat.reject ? ST_STATUS : ST_ADD;
			end
			ST_ADD: begin
				dp_cmd.add = 1'b1;
				state_d = ST_FIND;
			end
			ST_FIND: begin
				dp_cmd.sel_pos = 1'b1;
				if (dp_stat.find_more) begin
					dp_cmd.find_step = 1'b1;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				dp_cmd.insert = 1'b1;
				state_d = ST_STATUS;
			end
			ST_STATUS: begin
				out_valid = 1'b1;
				out_last = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/tuaq_dp.sv
module tuaq_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tuaq_pkg::dp_cmd_t             dp_cmd,
	output tuaq_pkg::dp_stat_t            dp_stat,
	input  logic [tuaq_pkg::QUANT_W-1:0]  ticks_per_quantum,
	input  logic [tuaq_pkg::SECS_W-1:0]   alarm_seconds,
	input  logic [tuaq_pkg::TAG_W-1:0]    alarm_tag,
	input  logic [tuaq_pkg::CNT48_W-1:0]  new_wall_time,
	output logic [tuaq_pkg::TAG_W-1:0]    fired_tag,
	output logic                          status,
	output logic                          quantum_expired,
	output logic [tuaq_pkg::UP_W-1:0]     uptime_ms,
	output logic [tuaq_pkg::CNT48_W-1:0]  tick_total,
	output logic [tuaq_pkg::CNT48_W-1:0]  wall_seconds,
	output logic [tuaq_pkg::CNT_W-1:0]    alarms_pending
);
	import tuaq_pkg::*;

	// Counters and uptime.
	logic [MS_W-1:0] ms_q;
	logic [CNT48_W-1:0] secs_q;
	logic [UP_W-1:0] up_q;
	logic [CNT48_W-1:0] ticks_q;
	logic [CNT48_W-1:0] wall_q;
	logic [QUANT_W-1:0] quant_q;
	logic [QUANT_W:0] quant_inc;
	logic qexp_q;
	logic status_q;

	// Item fields and insert arithmetic.
	logic [SECS_W-1:0] isecs_q;
	logic [TAG_W-1:0] itag_q;
	logic [PROD_W-1:0] prod_q;
	logic [UP_W-1:0] new_trig_q;

	// Sorted alarm table, slot zero holds the earliest trigger.
	logic [UP_W-1:0] trig_q [ALARM_SLOTS];
	logic [TAG_W-1:0] tag_q [ALARM_SLOTS];
	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] fire_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] rd_idx;
	logic [UP_W-1:0] rd_trig;
	logic sec_wrap;

	assign quant_inc = {1'b0, quant_q} + (QUANT_W + 1)'(1);
	assign sec_wrap = (ms_q == MS_LAST) && (&secs_q);

	// One table read port, shared by the due scan and the insert search.
	assign rd_idx = dp_cmd.sel_pos ? pos_q : fire_q;
	assign rd_trig = trig_q[rd_idx[IDX_W-1:0]];

	assign dp_stat.due = (fire_q < occ_q) && (rd_trig <= up_q);
	assign dp_stat.find_more = (pos_q < occ_q) && (rd_trig < new_trig_q);
	assign dp_stat.reject = (isecs_q == '0) || (occ_q >= CNT_W'(ALARM_SLOTS));
	assign dp_stat.last_fire = (fire_q == CNT_W'(1));
	assign dp_stat.any_fired = (fire_q != '0);

	// Result fields.
	assign fired_tag = dp_cmd.show_fire ? tag_q[0] : '0;
	assign status = status_q;
	assign quantum_expired = qexp_q;
	assign uptime_ms = up_q;
	assign tick_total = ticks_q;
	assign wall_seconds = wall_q;
	assign alarms_pending = occ_q - fire_q;

	// Control state: counters, occupancy and step flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
			secs_q <= '0;
			up_q <= '0;
			ticks_q <= '0;
			wall_q <= '0;
			quant_q <= '0;
			qexp_q <= 1'b0;
			status_q <= 1'b0;
			occ_q <= '0;
			fire_q <= '0;
			pos_q <= '0;
		end else begin
			if (dp_cmd.load) begin
				qexp_q <= 1'b0;
				status_q <= 1'b0;
				fire_q <= '0;
				pos_q <= '0;
			end
			if (dp_cmd.cancel) begin
				occ_q <= '0;
			end
			if (dp_cmd.set_wall) begin
				wall_q <= new_wall_time;
			end
			// Tick: the uptime restarts at zero when the seconds count wraps.
			if (dp_cmd.tick) begin
				ticks_q <= ticks_q + CNT48_W'(1);
				up_q <= sec_wrap ? '0 : up_q + UP_W'(1);
				if (ms_q == MS_LAST) begin
					ms_q <= '0;
					secs_q <= secs_q + CNT48_W'(1);
					wall_q <= wall_q + CNT48_W'(1);
				end else begin
					ms_q <= ms_q + MS_W'(1);
				end
				if (quant_inc >= {1'b0, ticks_per_quantum}) begin
					quant_q <= '0;
					qexp_q <= 1'b1;
				end else begin
					quant_q <= quant_inc[QUANT_W-1:0];
				end
			end
			if (dp_cmd.scan_step) begin
				fire_q <= fire_q + CNT_W'(1);
			end
			// Each fired transfer removes the head alarm.
			if (dp_cmd.pop) begin
				fire_q <= fire_q - CNT_W'(1);
				occ_q <= occ_q - CNT_W'(1);
			end
			if (dp_cmd.mul) begin
				status_q <= dp_stat.reject;
			end
			if (dp_cmd.find_step) begin
				pos_q <= pos_q + CNT_W'(1);
			end
			if (dp_cmd.insert) begin
				occ_q <= occ_q + CNT_W'(1);
			end
		end
	end

	// Item fields and trigger arithmetic.
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			isecs_q <= alarm_seconds;
			itag_q <= alarm_tag;
		end
		if (dp_cmd.mul) begin
			prod_q <= PROD_W'(isecs_q) * PROD_W'(MS_PER_SEC);
		end
		if (dp_cmd.add) begin
			new_trig_q <= up_q + UP_W'(prod_q);
		end
	end

	// Table shifts: down by one on a pop, up above the slot on an insert.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ALARM_SLOTS; i++) begin
			if (dp_cmd.pop) begin
				if (i < ALARM_SLOTS - 1) begin
					trig_q[i] <= trig_q[i + 1];
					tag_q[i] <= tag_q[i + 1];
				end
			end else if (dp_cmd.insert) begin
				if (CNT_W'(i) == pos_q) begin
					trig_q[i] <= new_trig_q;
					tag_q[i] <= itag_q;
				end else if ((CNT_W'(i) > pos_q) && (i > 0)) begin
					trig_q[i] <= trig_q[i - 1];
					tag_q[i] <= tag_q[i - 1];
				end
			end
		end
	end

endmodule

FILE: tb/tick_uptime_alarm_queue_test.sv
`timescale 1ns / 100ps

module tick_uptime_alarm_queue_test;
	import tuaq_pkg::*;

	localparam int REG_BYTES = 4;
	localparam int MS_PER_S = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 230;
	localparam int ROUND_CAP = 60;
	localparam int REPORT_LIMIT = 10;
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST = 3'd7;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [SECS_W-1:0] MAX_SECS = 22'h3F_FFFF;

	// One result as it travels on the result stream.
	typedef struct packed {
		logic              kind;
		logic [TAG_W-1:0]  tag;
		logic              status;
		logic              qexp;
		logic [UP_W-1:0]   uptime;
		logic [47:0]       ticks;
		logic [47:0]       wall;
		logic [CNT_W-1:0]  pending;
		logic              last;
	} result_t;

	// One line of the directed plan: a register write or a command repeated reps times.
	typedef struct {
		bit                 is_write;
		reg_idx_t           reg_sel;
		logic [DATA_W-1:0]  reg_val;
		logic [CMD_W-1:0]   code;
		int                 reps;
		logic [SECS_W-1:0]  secs;
		logic [TAG_W-1:0]   tag;
		logic [47:0]        wall;
		bit                 typed;
		result_t            want;
	} row_t;

	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic [CMD_W-1:0]    s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	// Timer state as the block should hold it.
	bit                  cfg_enable = 1'b0;
	logic [QUANT_W-1:0]  cfg_quantum = QUANT_RESET;
	int                  ms_part = 0;
	logic [47:0]         up_secs = '0;
	logic [47:0]         tick_total = '0;
	logic [47:0]         wall_secs = '0;
	int                  quantum_count = 0;
	logic [UP_W-1:0]     slot_time [ALARM_SLOTS];
	logic [TAG_W-1:0]    slot_tag [ALARM_SLOTS];
	int                  occupied = 0;

	result_t             timer_results [$];
	row_t                plan [$];
	result_t             seen;
	int                  mismatch_count = 0;
	int                  items_taken = 0;
	int                  burst_left = 0;
	rx_mode_t            rx_mode = RX_OPEN;
	int                  rx_left = 0;

	tick_uptime_alarm_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [UP_W-1:0] uptime_now();
		return UP_W'(up_secs * 64'd1000 + 64'(ms_part));
	endfunction

	function automatic result_t state_res(input logic kind, input logic [TAG_W-1:0] tag,
			input logic reject, input logic expired, input logic last);
		result_t r;
		r.kind = kind;
		r.tag = tag;
		r.status = reject;
		r.qexp = expired;
		r.uptime = uptime_now();
		r.ticks = tick_total;
		r.wall = wall_secs;
		r.pending = CNT_W'(occupied);
		r.last = last;
		return r;
	endfunction

	function automatic result_t status_res(input logic reject, input logic expired,
			input logic [UP_W-1:0] up, input logic [47:0] ticks, input logic [47:0] wall_v,
			input logic [CNT_W-1:0] pend);
		result_t r;
		r.kind = 1'b0;
		r.tag = '0;
		r.status = reject;
		r.qexp = expired;
		r.uptime = up;
		r.ticks = ticks;
		r.wall = wall_v;
		r.pending = pend;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic string fmt_res(input result_t r);
		return $sformatf({"kind=%0d tag=%h status=%0d qexp=%0d up=%0d ticks=%0d",
			" wall=%0d pend=%0d last=%0d"},
			r.kind, r.tag, r.status, r.qexp, r.uptime, r.ticks, r.wall, r.pending, r.last);
	endfunction

	function automatic row_t cmd_row(input logic [CMD_W-1:0] code, input int reps,
			input logic [SECS_W-1:0] secs, input logic [TAG_W-1:0] tag, input logic [47:0] wall_v);
		row_t r;
		r.is_write = 1'b0;
		r.reg_sel = REG_ENABLE;
		r.reg_val = '0;
		r.code = code;
		r.reps = reps;
		r.secs = secs;
		r.tag = tag;
		r.wall = wall_v;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t typed_row(input logic [CMD_W-1:0] code, input logic [SECS_W-1:0] secs,
			input logic [TAG_W-1:0] tag, input logic [47:0] wall_v, input result_t want);
		row_t r;
		r = cmd_row(code, 1, secs, tag, wall_v);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic row_t reg_row(input reg_idx_t sel, input logic [DATA_W-1:0] val);
		row_t r;
		r = cmd_row(CMD_STATUS, 0, '0, '0, '0);
		r.is_write = 1'b1;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	// Mostly short delays; some zero and some huge.
	function automatic logic [SECS_W-1:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		else if (r < 14)
			return SECS_W'($urandom);
		else if (r < 70)
			return SECS_W'(1);
		else
			return SECS_W'(2);
	endfunction

	function automatic logic [QUANT_W-1:0] pick_quantum();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return QUANT_W'(1);
			2: return '1;
			default: return QUANT_W'($urandom_range(2, 40));
		endcase
	endfunction

	// Applies one accepted command to the timer state and queues the results it gives.
	task automatic timer_step(input logic [CMD_W-1:0] code, input logic [SECS_W-1:0] secs,
			input logic [TAG_W-1:0] tag, input logic [47:0] wall_v);
		logic [TAG_W-1:0] fired_tags [$];
		logic             reject;
		logic             expired;
		logic [UP_W-1:0]  trig;
		int               pos;
		reject = 1'b0;
		expired = 1'b0;
		case (code)
			CMD_TICK: begin
				if (cfg_enable) begin
					tick_total = tick_total + 48'd1;
					ms_part = ms_part + 1;
					if (ms_part >= MS_PER_S) begin
						ms_part = 0;
						up_secs = up_secs + 48'd1;
						wall_secs = wall_secs + 48'd1;
					end
					// Due alarms sit at the head of the sorted table.
					while (fired_tags.size() < occupied &&
							slot_time[fired_tags.size()] <= uptime_now())
						fired_tags.push_back(slot_tag[fired_tags.size()]);
					for (int i = fired_tags.size(); i < occupied; i++) begin
						slot_time[i - fired_tags.size()] = slot_time[i];
						slot_tag[i - fired_tags.size()] = slot_tag[i];
					end
					occupied = occupied - fired_tags.size();
					quantum_count = quantum_count + 1;
					if (quantum_count >= int'(cfg_quantum)) begin
						quantum_count = 0;
						expired = 1'b1;
					end
				end
			end
			CMD_ADD: begin
				if (secs == '0 || occupied >= ALARM_SLOTS) begin
					reject = 1'b1;
				end else begin
					trig = uptime_now() + UP_W'(secs) * UP_W'(MS_PER_S);
					// A new alarm goes ahead of others with the same trigger.
					pos = 0;
					while (pos < occupied && slot_time[pos] < trig)
						pos++;
					for (int i = occupied; i > pos; i--) begin
						slot_time[i] = slot_time[i - 1];
						slot_tag[i] = slot_tag[i - 1];
					end
					slot_time[pos] = trig;
					slot_tag[pos] = tag;
					occupied++;
				end
			end
			CMD_CANCEL: occupied = 0;
			CMD_SET_WALL: wall_secs = wall_v;
			default: ;
		endcase
		foreach (fired_tags[i])
			timer_results.push_back(state_res(1'b1, fired_tags[i], 1'b0, expired, 1'b0));
		timer_results.push_back(state_res(1'b0, '0, reject, expired, 1'b1));
	endtask

	// Sends one command and waits for its transfer; bursts and gaps are chosen here.
	task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [SECS_W-1:0] secs,
			input logic [TAG_W-1:0] tag, input logic [47:0] wall_v,
			input bit typed = 1'b0, input result_t want = '0);
		s_tuser <= code;
		s_tdata <= IN_W'({wall_v, tag, secs});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		timer_step(code, secs, tag, wall_v);
		if (typed)
			timer_results[timer_results.size() - 1] = want;
		items_taken++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 10);
		end
	endtask

	// Any command other than a tick, with random content.
	task automatic send_misc();
		case ($urandom_range(0, 11))
			0: send_cmd(CMD_CANCEL, SECS_W'($urandom), TAG_W'($urandom), rand48());
			1, 2: send_cmd(CMD_STATUS, SECS_W'($urandom), TAG_W'($urandom), rand48());
			3, 4: send_cmd(CMD_SET_WALL, SECS_W'($urandom), TAG_W'($urandom),
				($urandom_range(0, 3) == 0) ? MAX48 - 48'($urandom_range(0, 2)) : rand48());
			5: send_cmd(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
				SECS_W'($urandom), TAG_W'($urandom), rand48());
			default: send_cmd(CMD_ADD, pick_delay(), TAG_W'($urandom), rand48());
		endcase
	endtask

	task automatic send_tick();
		send_cmd(CMD_TICK, SECS_W'($urandom), TAG_W'($urandom), rand48());
	endtask

	// Holds off the sender until every expected result has come and the block is quiet.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (timer_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t sel, input logic [DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(sel) * REG_BYTES);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_ENABLE)
			cfg_enable = val[0];
		else
			cfg_quantum = val[QUANT_W-1:0];
	endtask

	// Receiver: ready pattern switches between open, half and sparse stretches.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_HALF: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Each result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen.kind = m_tuser;
			seen.tag = m_tdata[15:0];
			seen.status = m_tdata[16];
			seen.qexp = m_tdata[17];
			seen.uptime = m_tdata[75:18];
			seen.ticks = m_tdata[123:76];
			seen.wall = m_tdata[171:124];
			seen.pending = m_tdata[176:172];
			seen.last = m_tlast;
			if (timer_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: %0t: result with none expected: %s", $realtime, fmt_res(seen));
			end else if (seen !== timer_results[0]) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("ERROR: %0t: result mismatch\n  expected %s\n  actual   %s",
						$realtime, fmt_res(timer_results[0]), fmt_res(seen));
				void'(timer_results.pop_front());
			end else begin
				void'(timer_results.pop_front());
			end
		end
	end

	initial begin
		int rounds;
		int item_base;

		// Reset values, extremes and rejections, then the quantum at its limits.
		plan.push_back(typed_row(CMD_STATUS, '0, '0, '0,
			status_res(1'b0, 1'b0, '0, '0, '0, '0)));
		plan.push_back(typed_row(CMD_TICK, MAX_SECS, '1, MAX48,
			status_res(1'b0, 1'b0, '0, '0, '0, '0)));
		plan.push_back(typed_row(CMD_ADD, '0, 16'h1234, '0,
			status_res(1'b1, 1'b0, '0, '0, '0, '0)));
		plan.push_back(typed_row(CMD_ADD, MAX_SECS, '1, '0,
			status_res(1'b0, 1'b0, '0, '0, '0, CNT_W'(1))));
		plan.push_back(typed_row(CMD_CANCEL, '0, '0, '0,
			status_res(1'b0, 1'b0, '0, '0, '0, '0)));
		plan.push_back(typed_row(CMD_SET_WALL, '0, '0, MAX48,
			status_res(1'b0, 1'b0, '0, '0, MAX48, '0)));
		plan.push_back(typed_row(CMD_SPARE_FIRST, '0, '0, '0,
			status_res(1'b0, 1'b0, '0, '0, MAX48, '0)));
		plan.push_back(typed_row(CMD_SPARE_LAST, MAX_SECS, '1, MAX48,
			status_res(1'b0, 1'b0, '0, '0, MAX48, '0)));
		plan.push_back(reg_row(REG_ENABLE, 32'd1));
		plan.push_back(reg_row(REG_QUANTUM, 32'd1));
		plan.push_back(typed_row(CMD_TICK, '0, '0, '0,
			status_res(1'b0, 1'b1, UP_W'(1), 48'd1, MAX48, '0)));
		plan.push_back(typed_row(CMD_TICK, '0, '0, '0,
			status_res(1'b0, 1'b1, UP_W'(2), 48'd2, MAX48, '0)));
		plan.push_back(reg_row(REG_QUANTUM, 32'd0));
		plan.push_back(typed_row(CMD_TICK, '0, '0, '0,
			status_res(1'b0, 1'b1, UP_W'(3), 48'd3, MAX48, '0)));
		plan.push_back(reg_row(REG_QUANTUM, 32'hFFFF));
		plan.push_back(typed_row(CMD_TICK, '0, '0, '0,
			status_res(1'b0, 1'b0, UP_W'(4), 48'd4, MAX48, '0)));
		plan.push_back(cmd_row(CMD_ADD, 1, 22'd1, 16'h0001, '0));
		plan.push_back(cmd_row(CMD_ADD, 1, 22'd1, 16'h0002, '0));
		plan.push_back(cmd_row(CMD_ADD, 1, 22'd2, 16'h8003, '0));
		plan.push_back(cmd_row(CMD_ADD, 1, 22'd1, 16'h0000, '0));
		// A short run of ticks; the queued alarms stay in place.
		plan.push_back(cmd_row(CMD_TICK, 20, '0, '0, '0));
		// Quantum lowered below the running count expires on the next tick.
		plan.push_back(reg_row(REG_QUANTUM, 32'd5));
		plan.push_back(cmd_row(CMD_TICK, 1, '0, '0, '0));
		// Fill the table; the adds beyond its size are refused.
		plan.push_back(cmd_row(CMD_ADD, ALARM_SLOTS, 22'd1, 16'h0100, '0));
		plan.push_back(cmd_row(CMD_ADD, 1, 22'd1, 16'hDEAD, '0));
		plan.push_back(cmd_row(CMD_TICK, 10, '0, '0, '0));
		plan.push_back(cmd_row(CMD_ADD, 1, 22'd3, 16'hBEEF, '0));
		plan.push_back(cmd_row(CMD_CANCEL, 1, '0, '0, '0));
		plan.push_back(cmd_row(CMD_STATUS, 1, '0, '0, '0));
		plan.push_back(reg_row(REG_QUANTUM, 32'd10));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				drain_results();
				reg_write(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				for (int r = 0; r < plan[i].reps; r++)
					send_cmd(plan[i].code, plan[i].secs, plan[i].tag + TAG_W'(r), plan[i].wall,
						plan[i].typed, plan[i].want);
			end
		end

		// Random rounds: a few adds and other commands, then a run of ticks.
		item_base = items_taken;
		rounds = 0;
		while (items_taken - item_base < RANDOM_ITEMS && rounds < ROUND_CAP) begin
			if (rounds == 0 || $urandom_range(0, 3) == 0) begin
				drain_results();
				reg_write(REG_QUANTUM, DATA_W'(pick_quantum()));
			end
			if (rounds == 2) begin
				// While disabled, ticks must leave every counter and alarm alone.
				drain_results();
				reg_write(REG_ENABLE, 32'd0);
				repeat (20) begin
					if ($urandom_range(0, 3) == 0)
						send_misc();
					else
						send_tick();
				end
				drain_results();
				reg_write(REG_ENABLE, 32'd1);
			end
			if ($urandom_range(0, 7) == 0) begin
				// Fill the table, then one add that must be refused.
				while (occupied < ALARM_SLOTS)
					send_cmd(CMD_ADD, SECS_W'($urandom_range(1, 2)), TAG_W'($urandom), rand48());
				send_cmd(CMD_ADD, SECS_W'($urandom_range(1, 2)), TAG_W'($urandom), rand48());
			end else begin
				repeat ($urandom_range(1, 4))
					send_cmd(CMD_ADD, pick_delay(), TAG_W'($urandom), rand48());
			end
			repeat ($urandom_range(0, 2))
				send_misc();
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(0, 9) == 0)
					send_misc();
				else
					send_tick();
			end
			rounds++;
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
